>>> design/bemf_pkg.sv
// Shared types, constants and helper functions of the back-EMF observer angle unit.
package bemf_pkg;

   // Widths of internal observer and angle values
   localparam int E_W          = 33;  // back-EMF estimate, signed Q16.16
   localparam int CX_W         = 37;  // CORDIC x/y, covers gain growth
   localparam int Z_W          = 30;  // CORDIC angle accumulator
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = 5;

   // Angle units are 1/(10430*4096) rad
   localparam logic signed [Z_W-1:0] PI_UNITS     = 30'sd134212859;
   localparam logic signed [Z_W-1:0] TWO_PI_UNITS = 30'sd268425719;

   // Register reset values
   localparam logic [15:0] GAIN_RESET = 16'd655;
   localparam logic [19:0] RES_RESET  = 20'd49152;
   localparam logic [15:0] TSL_RESET  = 16'd2789;

   // Register indexes on the CSR port
   typedef enum logic [1:0] {
      REG_GAIN = 2'd0,
      REG_RES  = 2'd1,
      REG_TSL  = 2'd2
   } reg_idx_type;

   // Observer gains shared by both lanes
   typedef struct packed {
      logic [15:0] switching_gain;
      logic [19:0] phase_resistance;
      logic [15:0] ts_over_ls;
   } gains_type;

   // arctan(2^-k) in angle units
   function automatic logic [24:0] atan_units(input logic [ATAN_IDX_W-1:0] k);
      logic [24:0] r;
      case (k)
         5'd0:    r = 25'd33553215;
         5'd1:    r = 25'd19807619;
         5'd2:    r = 25'd10465802;
         5'd3:    r = 25'd5312605;
         5'd4:    r = 25'd2666611;
         5'd5:    r = 25'd1334606;
         5'd6:    r = 25'd667466;
         5'd7:    r = 25'd333753;
         5'd8:    r = 25'd166879;
         5'd9:    r = 25'd83440;
         5'd10:   r = 25'd41720;
         5'd11:   r = 25'd20860;
         5'd12:   r = 25'd10430;
         5'd13:   r = 25'd5215;
         5'd14:   r = 25'd2608;
         5'd15:   r = 25'd1304;
         5'd16:   r = 25'd652;
         5'd17:   r = 25'd326;
         5'd18:   r = 25'd163;
         5'd19:   r = 25'd81;
         5'd20:   r = 25'd41;
         5'd21:   r = 25'd20;
         5'd22:   r = 25'd10;
         5'd23:   r = 25'd5;
         default: r = 25'd0;
      endcase
      return r;
   endfunction

   // Q16.16 back-EMF to counts: round half up, saturate to int16
   function automatic logic signed [15:0] emf_round(input logic signed [E_W-1:0] e);
      logic signed [E_W:0]    r;
      logic signed [E_W-16:0] q;
      logic signed [15:0]     res;
      r = (E_W+1)'(e) + (E_W+1)'(32768);
      q = r[E_W:16];
      if (q > (E_W-15)'(32767))
         res = 16'sh7FFF;
      else if (q < -(E_W-15)'(32768))
         res = 16'sh8000;
      else
         res = q[15:0];
      return res;
   endfunction

endpackage

>>> design/back_emf_observer_angle_unit.sv
// Top level: CSR block, two observer lanes, CORDIC angle merge and result register.
//
//   port group | dir | role
//   req_*      | in  | voltages and currents, one item per control tick
//   rsp_*      | out | rotor angle and saturated back-EMF, one item per request
//   csr_*      | i/o | gain, resistance and ts/Ls registers
//
// An item goes from accept through the lane multiply chain, the CORDIC loop of
// CORDIC_STEPS steps and the result register to rsp_tvalid.
// One item is in work at a time; req_tready is high only while no item is in work.
// A finished result waits in the output register, so a new item is taken while
// rsp_tready is low; the next result is held until that register is free.
// Reset clears the current estimates and loads the register defaults.
module back_emf_observer_angle_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // v_alpha, v_beta, i_alpha, i_beta
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // rotor_angle, emf_alpha, emf_beta
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bemf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LANES,
      ST_ANGLE,
      ST_HOLD
   } state_type;

   state_type             state_ff;
   gains_type             gains_ff;
   logic                  rsp_tvalid_ff;
   logic [47:0]           rsp_tdata_ff;
   logic                  accept, out_free, csr_write, rsp_load;
   logic [1:0]            lane_done;
   logic signed [E_W-1:0] emf_a, emf_b;
   logic                  cordic_start, cordic_done;
   logic [15:0]           angle;
   logic [47:0]           result;

   assign accept       = req_tvalid && req_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign out_free     = !rsp_tvalid_ff || rsp_tready;
   assign cordic_start = (state_ff == ST_LANES) && lane_done[0];
   assign result       = {emf_round(emf_b), emf_round(emf_a), angle};
   assign rsp_load     = out_free &&
                         (((state_ff == ST_ANGLE) && cordic_done) || (state_ff == ST_HOLD));

   // CSR registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.switching_gain   <= GAIN_RESET;
         gains_ff.phase_resistance <= RES_RESET;
         gains_ff.ts_over_ls       <= TSL_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_GAIN: gains_ff.switching_gain   <= csr_pwdata[15:0];
            REG_RES:  gains_ff.phase_resistance <= csr_pwdata[19:0];
            REG_TSL:  gains_ff.ts_over_ls       <= csr_pwdata[15:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_GAIN: csr_prdata = {16'd0, gains_ff.switching_gain};
         REG_RES:  csr_prdata = {12'd0, gains_ff.phase_resistance};
         REG_TSL:  csr_prdata = {16'd0, gains_ff.ts_over_ls};
         default:  csr_prdata = '0;
      endcase
   end

   // Observer lanes, alpha and beta
   bemf_lane u_lane_alpha (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .volt  ($signed(req_tdata[15:0])),
      .curr  ($signed(req_tdata[47:32])),
      .gains (gains_ff),
      .emf   (emf_a),
      .done  (lane_done[0])
   );

   bemf_lane u_lane_beta (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .volt  ($signed(req_tdata[31:16])),
      .curr  ($signed(req_tdata[63:48])),
      .gains (gains_ff),
      .emf   (emf_b),
      .done  (lane_done[1])
   );

   // Angle merge
   bemf_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .emf_a (emf_a),
      .emf_b (emf_b),
      .angle (angle),
      .done  (cordic_done)
   );

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff  <= result;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept)
                  state_ff <= ST_LANES;
            end
            ST_LANES: begin
               if (lane_done[0])
                  state_ff <= ST_ANGLE;
            end
            ST_ANGLE: begin
               if (cordic_done)
                  state_ff <= out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
               if (out_free)
                  state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Checks
   a_lane_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] == lane_done[1])
      else $error("observer lanes out of step");

   a_lane_state: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> state_ff == ST_LANES)
      else $error("lane finished outside lane phase");

   a_angle_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_ANGLE)
      else $error("angle finished outside angle phase");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second item taken while one is in work");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_ANGLE || $past(state_ff) == ST_HOLD))
      else $error("result raised without a finished angle");

endmodule

>>> design/bemf_lane.sv
// One observer lane: back-EMF estimate and current-estimate update for one axis.
module bemf_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [15:0]                volt,
   input  logic signed [15:0]                curr,
   input  bemf_pkg::gains_type               gains,
   output logic signed [bemf_pkg::E_W-1:0]   emf,
   output logic                              done
);
   import bemf_pkg::*;

   localparam logic signed [37:0] EST_MAX = 38'sd2147483647;
   localparam logic signed [37:0] EST_MIN = -38'sd2147483648;

   logic signed [31:0]    est_ff, est_in;
   logic signed [15:0]    volt_ff;
   logic signed [32:0]    delta_ff, delta_in;
   logic signed [49:0]    e_prod;
   logic signed [52:0]    rt_prod;
   logic signed [53:0]    inc_prod;
   logic signed [E_W-1:0] e_ff;
   logic signed [35:0]    rterm_ff;
   logic signed [36:0]    drive_ff, drive_in, inc_ff;
   logic signed [37:0]    sum;
   logic [4:0]            stg_ff;

   // Datapath: delta, then products, then drive, then increment, then saturate
   always_comb begin
      delta_in = 33'(est_ff) - 33'($signed({curr, 16'd0}));
      e_prod   = 50'(delta_ff) * 50'($signed({1'b0, gains.switching_gain}));
      rt_prod  = 53'(est_ff) * 53'($signed({1'b0, gains.phase_resistance}));
      drive_in = 37'($signed({volt_ff, 16'd0})) - 37'(rterm_ff) - 37'(e_ff);
      inc_prod = 54'(drive_ff) * 54'($signed({1'b0, gains.ts_over_ls}));
      sum      = 38'(est_ff) + 38'(inc_ff);
      if (sum > EST_MAX)
         est_in = 32'sh7FFFFFFF;
      else if (sum < EST_MIN)
         est_in = 32'sh80000000;
      else
         est_in = sum[31:0];
   end

   // Stage tokens and observer state
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff <= '0;
         est_ff <= '0;
      end else begin
         stg_ff <= {stg_ff[3:0], start};
         if (stg_ff[3])
            est_ff <= est_in;
      end
   end

   // Payload stages; floor shift is the upper slice of each product
   always_ff @(posedge clock) begin
      if (start) begin
         delta_ff <= delta_in;
         volt_ff  <= volt;
      end
      if (stg_ff[0]) begin
         e_ff     <= e_prod[48:16];
         rterm_ff <= rt_prod[51:16];
      end
      if (stg_ff[1])
         drive_ff <= drive_in;
      if (stg_ff[2])
         inc_ff <= inc_prod[52:16];
   end

   assign emf  = e_ff;
   assign done = stg_ff[4];

endmodule

>>> design/bemf_cordic.sv
// Merge stage: iterative CORDIC vectoring for atan2(-emf_a, emf_b), one step a cycle.
module bemf_cordic #(
   parameter int STEPS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [bemf_pkg::E_W-1:0]  emf_a,
   input  logic signed [bemf_pkg::E_W-1:0]  emf_b,
   output logic [15:0]                      angle,
   output logic                             done
);
   import bemf_pkg::*;

   logic signed [CX_W-1:0]  x_ff, y_ff, x_in, y_in, xs, ys;
   logic signed [CX_W-1:0]  x0, y0, x_load, y_load;
   logic signed [Z_W-1:0]   z_ff, z_in, z_load, z_wrap, atan_z;
   logic [ATAN_IDX_W-1:0]   k_ff;
   logic                    busy_ff, done_ff;
   logic [15:0]             angle_ff;

   // Initial vector, rotated by pi when it points into the left half plane
   always_comb begin
      x0 = CX_W'(emf_b);
      y0 = -CX_W'(emf_a);
      if (x0 < 0) begin
         x_load = -x0;
         y_load = -y0;
         z_load = (y0 >= 0) ? PI_UNITS : -PI_UNITS;
      end else begin
         x_load = x0;
         y_load = y0;
         z_load = '0;
      end
   end

   // One micro-rotation toward y = 0
   always_comb begin
      xs     = x_ff >>> k_ff;
      ys     = y_ff >>> k_ff;
      atan_z = Z_W'($signed({1'b0, atan_units(k_ff)}));
      priority if (y_ff > 0) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + atan_z;
      end else if (y_ff < 0) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - atan_z;
      end else begin
         x_in = x_ff;
         y_in = y_ff;
         z_in = z_ff;
      end
      z_wrap = (z_in < 0) ? z_in + TWO_PI_UNITS : z_in;
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (busy_ff) begin
            k_ff <= k_ff + 1'b1;
            if (k_ff == ATAN_IDX_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Vector and angle registers
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x_load;
         y_ff <= y_load;
         z_ff <= z_load;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         if (k_ff == ATAN_IDX_W'(STEPS - 1))
            angle_ff <= z_wrap[27:12];
      end
   end

   assign angle = angle_ff;
   assign done  = done_ff;

endmodule

>>> bench/back_emf_observer_angle_unit_test.sv
// Testbench for the back-EMF observer angle unit: directed and random items against a predictor.
`timescale 1ns / 100ps

module back_emf_observer_angle_unit_test;
   import bemf_pkg::*;

   localparam int ANGLE_STEPS    = 16;
   localparam int RESULT_LATENCY = ANGLE_STEPS + 6;
   localparam logic [1:0] UNUSED_IDX = 2'd3;
   localparam int MAX_REPORTS    = 50;

   // angle units are 1/(10430*4096) rad
   localparam longint ANGLE_PI     = 64'sd134212859;
   localparam longint ANGLE_TWO_PI = 64'sd268425719;
   localparam longint ATAN_STEP [0:23] = '{
      33553215, 19807619, 10465802, 5312605, 2666611, 1334606,
      667466, 333753, 166879, 83440, 41720, 20860,
      10430, 5215, 2608, 1304, 652, 326,
      163, 81, 41, 20, 10, 5
   };

   // request item, first field in the low bits
   typedef struct packed {
      logic signed [15:0] i_beta;
      logic signed [15:0] i_alpha;
      logic signed [15:0] v_beta;
      logic signed [15:0] v_alpha;
   } obs_input_type;

   // result item, first field in the low bits
   typedef struct packed {
      logic signed [15:0] emf_beta;
      logic signed [15:0] emf_alpha;
      logic [15:0]        rotor_angle;
   } obs_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;     // v_alpha, v_beta, i_alpha, i_beta
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;          // rotor_angle, emf_alpha, emf_beta
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   back_emf_observer_angle_unit #(.CORDIC_STEPS(ANGLE_STEPS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // observer copy: gains and current estimates
   gains_type          obs_gains;
   logic signed [31:0] est_alpha;
   logic signed [31:0] est_beta;
   obs_result_type     expected_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int recv_hold_left = 0;
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;

   // one observer lane: returns e in Q16.16 and advances the estimate
   function automatic longint observe_lane(input logic signed [15:0] volts,
                                           input logic signed [15:0] amps,
                                           inout logic signed [31:0] est);
      longint s, meas, delta, e, rterm, drive, nxt;
      longint g, r, t;
      g = obs_gains.switching_gain;
      r = obs_gains.phase_resistance;
      t = obs_gains.ts_over_ls;
      s = est;
      meas = amps;
      delta = s - meas * 65536;
      e = (delta * g) >>> 16;
      rterm = (s * r) >>> 16;
      meas = volts;
      drive = meas * 65536 - rterm - e;
      nxt = s + ((drive * t) >>> 16);
      if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
      if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
      est = nxt[31:0];
      return e;
   endfunction

   // Q16.16 to counts, round half up, saturate
   function automatic logic signed [15:0] emf_counts(input longint e);
      longint q;
      q = (e + 32768) >>> 16;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // CORDIC vectoring of (x = e_beta, y = -e_alpha), wrapped to [0, 2pi)
   function automatic logic [15:0] rotor_angle_of(input longint e_alpha,
                                                  input longint e_beta);
      longint x, y, z, xs, ys;
      int k;
      x = e_beta;
      y = -e_alpha;
      z = 0;
      // left half plane: rotate by pi first
      if (x < 0) begin
         z = (y >= 0) ? ANGLE_PI : -ANGLE_PI;
         x = -x;
         y = -y;
      end
      for (k = 0; k < ANGLE_STEPS; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_STEP[k];
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_STEP[k];
         end
      end
      if (z < 0) z = z + ANGLE_TWO_PI;
      return z[27:12];
   endfunction

   function automatic obs_result_type predict_observer(input obs_input_type item);
      longint ea, eb;
      obs_result_type res;
      ea = observe_lane(item.v_alpha, item.i_alpha, est_alpha);
      eb = observe_lane(item.v_beta, item.i_beta, est_beta);
      res.rotor_angle = rotor_angle_of(ea, eb);
      res.emf_alpha = emf_counts(ea);
      res.emf_beta = emf_counts(eb);
      return res;
   endfunction

   function automatic logic [15:0] random_field();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 5)
         return 16'($urandom);
      else if (pick < 8)
         return 16'($urandom_range(1024) - 512);
      case ($urandom_range(3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic obs_input_type make_item(input int va, input int vb,
                                               input int ia, input int ib);
      obs_input_type item;
      item.v_alpha = 16'(va);
      item.v_beta = 16'(vb);
      item.i_alpha = 16'(ia);
      item.i_beta = 16'(ib);
      return item;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_REPORTS)
         $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // APB write: setup cycle, then access cycle
   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_GAIN: obs_gains.switching_gain = value[15:0];
         REG_RES:  obs_gains.phase_resistance = value[19:0];
         REG_TSL:  obs_gains.ts_over_ls = value[15:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic write_gains(input logic [31:0] gain, input logic [31:0] res,
                              input logic [31:0] tsl);
      write_register(REG_GAIN, gain);
      write_register(REG_RES, res);
      write_register(REG_TSL, tsl);
   endtask

   // offer one item; valid stays high into the next call unless the sender idles
   task automatic send_item(input obs_input_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= item;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_observer(item));
      items_sent++;
   endtask

   // drop valid and wait for every outstanding result
   task automatic finish_items();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   // receiver: random stalls, plus a counted hold-off when requested
   always @(negedge clock) begin
      if (recv_hold_left > 0) begin
         rsp_tready <= 1'b0;
         recv_hold_left <= recv_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      obs_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, angle", int'(got.rotor_angle), -1);
         end else begin
            want = expected_results.pop_front();
            if (got.rotor_angle !== want.rotor_angle)
               report_mismatch("rotor_angle", int'(got.rotor_angle), int'(want.rotor_angle));
            if (got.emf_alpha !== want.emf_alpha)
               report_mismatch("emf_alpha", int'(got.emf_alpha), int'(want.emf_alpha));
            if (got.emf_beta !== want.emf_beta)
               report_mismatch("emf_beta", int'(got.emf_beta), int'(want.emf_beta));
         end
      end
   end

   // quadrants with frozen estimates, including both left-half-plane branches
   task automatic test_angle_quadrants();
      write_register(REG_TSL, 32'd0);
      send_item(make_item(0, 0, 0, 0));
      send_item(make_item(0, 0, 1000, -1000));
      send_item(make_item(0, 0, -1000, -1000));
      send_item(make_item(0, 0, -1000, 1000));
      send_item(make_item(0, 0, 1000, 1000));
      send_item(make_item(0, 0, 0, 1000));
      send_item(make_item(0, 0, 1000, 0));
      send_item(make_item(0, 0, -1000, 0));
      finish_items();
   endtask

   task automatic test_field_extremes();
      write_gains(32'd655, 32'd49152, 32'd2789);
      send_item(make_item(32767, 32767, -32768, -32768));
      send_item(make_item(-32768, -32768, 32767, 32767));
      send_item(make_item(32767, -32768, 32767, -32768));
      send_item(make_item(-1, -1, -1, -1));
      finish_items();
   endtask

   // drive the estimates into both saturation limits, then largest gains
   task automatic test_estimate_saturation();
      int n;
      write_gains(32'd0, 32'd0, 32'd65535);
      for (n = 0; n < 4; n++) send_item(make_item(32767, 32767, 0, 0));
      for (n = 0; n < 4; n++) send_item(make_item(-32768, -32768, 0, 0));
      finish_items();
      write_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(make_item(32767, -32768, -32768, 32767));
      send_item(make_item(-32768, 32767, 32767, -32768));
      finish_items();
   endtask

   // a write to the unused address must leave every gain alone
   task automatic test_unused_register();
      write_gains(32'd1200, 32'd30000, 32'd4000);
      write_register(UNUSED_IDX, $urandom);
      send_item(make_item(500, -700, 12, -34));
      send_item(make_item(-900, 300, -56, 78));
      finish_items();
   endtask

   // output held off long enough that the block backs up onto the input
   task automatic test_output_backpressure();
      int n;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      recv_hold_left = 400;
      for (n = 0; n < 12; n++)
         send_item(make_item(random_field(), random_field(), random_field(), random_field()));
      finish_items();
   endtask

   task automatic run_random_phase(input int count, input logic [31:0] gain,
                                   input logic [31:0] res, input logic [31:0] tsl);
      int n;
      write_gains(gain, res, tsl);
      for (n = 0; n < count; n++)
         send_item(make_item(random_field(), random_field(), random_field(), random_field()));
      finish_items();
   endtask

   task automatic test_slow_receiver();
      send_idle_pct = 38;
      recv_idle_pct = 85;
      run_random_phase(275, 32'd655, 32'd49152, 32'd2789);
      run_random_phase(275, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_slow_sender();
      send_idle_pct = 85;
      recv_idle_pct = 38;
      run_random_phase(275, $urandom, $urandom, $urandom);
      run_random_phase(275, 32'd0, $urandom, $urandom);
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(275, $urandom, $urandom, $urandom);
      run_random_phase(275, $urandom, 32'd0, $urandom_range(65535, 60000));
   endtask

   initial begin
      obs_gains.switching_gain = GAIN_RESET;
      obs_gains.phase_resistance = RES_RESET;
      obs_gains.ts_over_ls = TSL_RESET;
      est_alpha = '0;
      est_beta = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_angle_quadrants();
      test_field_extremes();
      test_estimate_saturation();
      test_unused_register();
      test_output_backpressure();
      test_slow_receiver();
      test_slow_sender();
      test_full_rate();

      $display("Covered %0d items and %0d results over %0d register writes,",
               items_sent, results_seen, csr_writes);
      $display("with angle quadrants, estimate saturation, gain extremes and output stalls.");
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> back_emf_observer_angle_unit.f
design/bemf_pkg.sv
design/bemf_lane.sv
design/bemf_cordic.sv
design/back_emf_observer_angle_unit.sv
bench/back_emf_observer_angle_unit_test.sv
